@@ src/ezlr_pkg.sv @@
// ----------------------------------------------------------------------------
// ezlr_pkg
// Shared widths, codes, command type and zone mapping functions for the
// eight-zone line rasterizer.
// ----------------------------------------------------------------------------
package ezlr_pkg;

    // Coordinate width of the ports; zone-0 values need one more bit,
    // decision terms two more on top of that.
    localparam int COORD_BITS  = 12;
    localparam int WALK_BITS   = COORD_BITS + 1;
    localparam int DEC_BITS    = COORD_BITS + 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        ZONE_0 = 3'd0,
        ZONE_1 = 3'd1,
        ZONE_2 = 3'd2,
        ZONE_3 = 3'd3,
        ZONE_4 = 3'd4,
        ZONE_5 = 3'd5,
        ZONE_6 = 3'd6,
        ZONE_7 = 3'd7
    } zone_t;

    typedef logic signed [WALK_BITS-1:0] walk_t;
    typedef logic signed [DEC_BITS-1:0]  dec_t;

    typedef struct packed {
        walk_t a;
        walk_t b;
    } pair_t;

    // One decoded beat on its way from the front end to the walker
    typedef struct packed {
        action_t     action;
        zone_t       zone;
        walk_t       u0;
        walk_t       v0;
        walk_t       u1;
        walk_t       du;
        walk_t       dv;
        logic [1:0]  color;
    } cmd_t;

    // Map an original (x, y) into zone 0 (u, v)
    function automatic pair_t to_zone0(zone_t z, walk_t x, walk_t y);
        pair_t r;
        case (z)
            ZONE_0: begin r.a = x;  r.b = y;  end
            ZONE_1: begin r.a = y;  r.b = x;  end
            ZONE_2: begin r.a = y;  r.b = -x; end
            ZONE_3: begin r.a = -x; r.b = y;  end
            ZONE_4: begin r.a = -x; r.b = -y; end
            ZONE_5: begin r.a = -y; r.b = -x; end
            ZONE_6: begin r.a = -y; r.b = x;  end
            ZONE_7: begin r.a = x;  r.b = -y; end
            default: begin r.a = x; r.b = y;  end
        endcase
        return r;
    endfunction

    // Map a zone-0 (u, v) back to the original (x, y)
    function automatic pair_t from_zone0(zone_t z, walk_t u, walk_t v);
        pair_t r;
        case (z)
            ZONE_0: begin r.a = u;  r.b = v;  end
            ZONE_1: begin r.a = v;  r.b = u;  end
            ZONE_2: begin r.a = -v; r.b = u;  end
            ZONE_3: begin r.a = -u; r.b = v;  end
            ZONE_4: begin r.a = -u; r.b = -v; end
            ZONE_5: begin r.a = -v; r.b = -u; end
            ZONE_6: begin r.a = v;  r.b = -u; end
            ZONE_7: begin r.a = u;  r.b = -v; end
            default: begin r.a = u; r.b = v;  end
        endcase
        return r;
    endfunction

endpackage

@@ src/eight_zone_line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// eight_zone_line_rasterizer
// Midpoint line rasterizer for any of eight zones.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): each beat is a load (s_action = 0) carrying two
//   signed endpoints and a color code, or a step (s_action = 1) that asks
//   for the next pixel. A load gives no output and replaces any unfinished
//   line; a step with no line active gives nothing.
//   Output channel (m_*): one beat per pixel, from the first endpoint to the
//   second, with m_last_pixel high on the second endpoint.
//   Throughput: one input beat per cycle while the queue has room, and one
//   pixel per cycle while m_ready stays high; the walker does one decision
//   add and one limit compare per pixel.
//   Path: two-entry command queue, walker, then the output register on m_*.
//   When the receiver stalls, the pixel holds in the output register, the
//   walker waits, and the queue fills; s_ready drops once it is full.
//   Reset (aresetn low, synchronous) empties the queue, drops the active
//   line and clears m_valid.
// ----------------------------------------------------------------------------
module eight_zone_line_rasterizer (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_action,
    input  logic signed [ezlr_pkg::COORD_BITS-1:0]  s_x_start,
    input  logic signed [ezlr_pkg::COORD_BITS-1:0]  s_y_start,
    input  logic signed [ezlr_pkg::COORD_BITS-1:0]  s_x_end,
    input  logic signed [ezlr_pkg::COORD_BITS-1:0]  s_y_end,
    input  logic        [1:0]                       s_color,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [ezlr_pkg::COORD_BITS-1:0]  m_pixel_x,
    output logic signed [ezlr_pkg::COORD_BITS-1:0]  m_pixel_y,
    output logic        [1:0]                       m_pixel_color,
    output logic                                    m_last_pixel
);

    ezlr_pkg::cmd_t push_cmd, head_cmd;
    logic           q_full, q_push, q_pop, q_head_valid;

    // Classify and map incoming beats
    ezlr_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_x_start (s_x_start),
        .s_y_start (s_y_start),
        .s_x_end   (s_x_end),
        .s_y_end   (s_y_end),
        .s_color   (s_color),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    // Decouple front end and walker
    ezlr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .cmd_in     (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .cmd_out    (head_cmd)
    );

    // Walk the line and emit pixels
    ezlr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (q_head_valid),
        .cmd           (head_cmd),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_last_pixel  (m_last_pixel)
    );

endmodule

@@ src/ezlr_front.sv @@
// ----------------------------------------------------------------------------
// ezlr_front
// Input side: classifies a load beat into one of eight zones and maps its
// endpoints and deltas into zone 0, then hands the command to the queue.
// ----------------------------------------------------------------------------
module ezlr_front (
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_action,
    input  logic signed [ezlr_pkg::COORD_BITS-1:0]  s_x_start,
    input  logic signed [ezlr_pkg::COORD_BITS-1:0]  s_y_start,
    input  logic signed [ezlr_pkg::COORD_BITS-1:0]  s_x_end,
    input  logic signed [ezlr_pkg::COORD_BITS-1:0]  s_y_end,
    input  logic        [1:0]                       s_color,
    input  logic                                    q_full,
    output logic                                    q_push,
    output ezlr_pkg::cmd_t                          q_cmd
);

    ezlr_pkg::walk_t x0, y0, x1, y1, dx, dy, ax, ay;
    ezlr_pkg::zone_t zone;
    ezlr_pkg::pair_t p0, p1, pd;
    logic            x_ge;

    // Widen endpoints and form the deltas
    assign x0 = ezlr_pkg::walk_t'(s_x_start);
    assign y0 = ezlr_pkg::walk_t'(s_y_start);
    assign x1 = ezlr_pkg::walk_t'(s_x_end);
    assign y1 = ezlr_pkg::walk_t'(s_y_end);
    assign dx = x1 - x0;
    assign dy = y1 - y0;

    // Compare magnitudes; a tie goes to the x-major zone
    assign ax   = dx[ezlr_pkg::WALK_BITS-1] ? -dx : dx;
    assign ay   = dy[ezlr_pkg::WALK_BITS-1] ? -dy : dy;
    assign x_ge = $unsigned(ax) >= $unsigned(ay);

    always_comb begin
        case ({dx[ezlr_pkg::WALK_BITS-1], dy[ezlr_pkg::WALK_BITS-1]})
            2'b00:   zone = x_ge ? ezlr_pkg::ZONE_0 : ezlr_pkg::ZONE_1;
            2'b10:   zone = x_ge ? ezlr_pkg::ZONE_3 : ezlr_pkg::ZONE_2;
            2'b11:   zone = x_ge ? ezlr_pkg::ZONE_4 : ezlr_pkg::ZONE_5;
            2'b01:   zone = x_ge ? ezlr_pkg::ZONE_7 : ezlr_pkg::ZONE_6;
            default: zone = ezlr_pkg::ZONE_0;
        endcase
    end

    // Mirror endpoints and deltas into zone 0
    assign p0 = ezlr_pkg::to_zone0(zone, x0, y0);
    assign p1 = ezlr_pkg::to_zone0(zone, x1, y1);
    assign pd = ezlr_pkg::to_zone0(zone, dx, dy);

    always_comb begin
        q_cmd.action = ezlr_pkg::action_t'(s_action);
        q_cmd.zone   = zone;
        q_cmd.u0     = p0.a;
        q_cmd.v0     = p0.b;
        q_cmd.u1     = p1.a;
        q_cmd.du     = pd.a;
        q_cmd.dv     = pd.b;
        q_cmd.color  = s_color;
    end

    // Accept a beat whenever the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

endmodule

@@ src/ezlr_queue.sv @@
// ----------------------------------------------------------------------------
// ezlr_queue
// Short command queue between the front end and the walker.
// ----------------------------------------------------------------------------
module ezlr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ezlr_pkg::cmd_t cmd_in,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output ezlr_pkg::cmd_t cmd_out
);

    ezlr_pkg::cmd_t                       mem_reg [ezlr_pkg::QUEUE_DEPTH];
    logic [ezlr_pkg::QPTR_BITS-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [ezlr_pkg::QPTR_BITS-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [ezlr_pkg::QCNT_BITS-1:0]       count_reg, count_next;
    logic                                 do_push, do_pop;

    assign full       = count_reg == ezlr_pkg::QCNT_BITS'(ezlr_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;
    assign cmd_out    = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == ezlr_pkg::QPTR_BITS'(ezlr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == ezlr_pkg::QPTR_BITS'(ezlr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming command
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

@@ src/ezlr_back.sv @@
// ----------------------------------------------------------------------------
// ezlr_back
// Walker: takes commands from the queue, sets up a line on load and emits
// one pixel per step of an active line into the output register.
// ----------------------------------------------------------------------------
module ezlr_back (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    head_valid,
    input  ezlr_pkg::cmd_t                          cmd,
    output logic                                    pop,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [ezlr_pkg::COORD_BITS-1:0]  m_pixel_x,
    output logic signed [ezlr_pkg::COORD_BITS-1:0]  m_pixel_y,
    output logic        [1:0]                       m_pixel_color,
    output logic                                    m_last_pixel
);

    logic               active_reg, active_next;
    ezlr_pkg::zone_t    zone_reg;
    ezlr_pkg::walk_t    walk_x_reg, walk_y_reg, limit_reg;
    ezlr_pkg::dec_t     decision_reg, east_reg, ne_reg;
    logic [1:0]         color_reg;
    logic               m_valid_reg, m_valid_next;
    logic signed [ezlr_pkg::COORD_BITS-1:0] px_reg, py_reg;
    logic [1:0]         pcolor_reg;
    logic               plast_reg;

    logic               is_load, out_free, emit, last;
    ezlr_pkg::pair_t    xy;
    ezlr_pkg::dec_t     dv2, du1, du2;

    assign is_load  = cmd.action == ezlr_pkg::ACT_LOAD;
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = head_valid && !is_load && active_reg && out_free;
    // Drop a step that finds no line; a load never waits
    assign pop      = head_valid && (is_load || !active_reg || out_free);

    assign last = walk_x_reg >= limit_reg;
    assign xy   = ezlr_pkg::from_zone0(zone_reg, walk_x_reg, walk_y_reg);

    // Setup terms: 2*dv, du and 2*du at decision width
    assign dv2 = {cmd.dv[ezlr_pkg::WALK_BITS-1], cmd.dv, 1'b0};
    assign du1 = {{2{cmd.du[ezlr_pkg::WALK_BITS-1]}}, cmd.du};
    assign du2 = {cmd.du[ezlr_pkg::WALK_BITS-1], cmd.du, 1'b0};

    always_comb begin
        active_next = active_reg;
        if (head_valid && is_load) begin
            active_next = 1'b1;
        end else if (emit && last) begin
            active_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Load a new line or advance the walk one column
    always_ff @(posedge aclk) begin
        if (head_valid && is_load) begin
            zone_reg     <= cmd.zone;
            walk_x_reg   <= cmd.u0;
            walk_y_reg   <= cmd.v0;
            limit_reg    <= cmd.u1;
            decision_reg <= dv2 - du1;
            east_reg     <= dv2;
            ne_reg       <= dv2 - du2;
            color_reg    <= cmd.color;
        end else if (emit && !last) begin
            walk_x_reg <= walk_x_reg + 1'b1;
            if (decision_reg[ezlr_pkg::DEC_BITS-1]) begin
                decision_reg <= decision_reg + east_reg;
            end else begin
                walk_y_reg   <= walk_y_reg + 1'b1;
                decision_reg <= decision_reg + ne_reg;
            end
        end
    end

    // Capture the pixel beat
    always_ff @(posedge aclk) begin
        if (emit) begin
            px_reg     <= xy.a[ezlr_pkg::COORD_BITS-1:0];
            py_reg     <= xy.b[ezlr_pkg::COORD_BITS-1:0];
            pcolor_reg <= color_reg;
            plast_reg  <= last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = px_reg;
    assign m_pixel_y     = py_reg;
    assign m_pixel_color = pcolor_reg;
    assign m_last_pixel  = plast_reg;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the eight-zone line rasterizer. A short table of
// directed beats covers a step before any load, the coordinate extremes, the
// zone ties and a load that cuts an unfinished line short. After it come
// random lines, most of them walked to the end and some cut short, mixed with
// stray steps. Both channels idle at random. Every pixel is checked against a
// midpoint walker kept in the bench or against a pixel typed in the table.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_CYCLES    = 200;
    localparam int DRAIN_CYCLES       = 8;
    localparam int TARGET_BEATS       = 1650;
    localparam int MAX_STEPS_PER_LINE = 150;
    localparam int COORD_MAX          = 2 ** (ezlr_pkg::COORD_BITS - 1) - 1;
    localparam int COORD_MIN          = -COORD_MAX - 1;
    localparam int DIR_ROWS           = 24;

    // Bit positions of the zone mirror code: swap axes, negate u, negate v
    localparam int MIR_SWAP  = 2;
    localparam int MIR_NEG_U = 1;
    localparam int MIR_NEG_V = 0;

    typedef logic signed [ezlr_pkg::COORD_BITS-1:0] coord_t;

    typedef struct {
        ezlr_pkg::action_t action;
        coord_t            x_start;
        coord_t            y_start;
        coord_t            x_end;
        coord_t            y_end;
        logic [1:0]        color;
    } line_cmd_t;

    typedef struct {
        coord_t     x;
        coord_t     y;
        logic [1:0] color;
        logic       last;
    } pixel_t;

    // How the expected pixel of a directed row is found
    typedef enum int {
        CHK_MODEL,
        CHK_NONE,
        CHK_PIXEL
    } chk_t;

    typedef struct {
        ezlr_pkg::action_t act;
        int                xs;
        int                ys;
        int                xe;
        int                ye;
        int                col;
        chk_t              chk;
        int                px;
        int                py;
        int                pcol;
        int                plast;
    } dir_row_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic       s_action  = 1'b0;
    coord_t     s_x_start = '0;
    coord_t     s_y_start = '0;
    coord_t     s_x_end   = '0;
    coord_t     s_y_end   = '0;
    logic [1:0] s_color   = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    coord_t     m_pixel_x;
    coord_t     m_pixel_y;
    logic [1:0] m_pixel_color;
    logic       m_last_pixel;

    pixel_t pending_pixels[$];
    pixel_t no_pixel;
    int     error_count  = 0;
    int     beats_sent   = 0;
    int     quiet_cycles = 0;
    int     src_calm     = 0;
    int     snk_calm     = 0;

    // Walker state: the active line in zone-0 coordinates
    logic            trace_active = 1'b0;
    ezlr_pkg::zone_t trace_zone   = ezlr_pkg::ZONE_0;
    ezlr_pkg::walk_t trace_u      = '0;
    ezlr_pkg::walk_t trace_v      = '0;
    ezlr_pkg::walk_t trace_u_end  = '0;
    ezlr_pkg::dec_t  trace_dec    = '0;
    ezlr_pkg::dec_t  trace_inc_e  = '0;
    ezlr_pkg::dec_t  trace_inc_ne = '0;
    logic [1:0]      trace_color  = '0;

    // Directed beats; a typed pixel only where it is plain to see
    dir_row_t dir_table [DIR_ROWS] = '{
        // step before any load, then a single-point line walked past its end
        '{ezlr_pkg::ACT_STEP,     0,     0,     0,     0, 0, CHK_NONE,      0,     0, 0, 0},
        '{ezlr_pkg::ACT_LOAD,     0,     0,     0,     0, 1, CHK_NONE,      0,     0, 0, 0},
        '{ezlr_pkg::ACT_STEP,     0,     0,     0,     0, 0, CHK_PIXEL,     0,     0, 1, 1},
        '{ezlr_pkg::ACT_STEP,    -1,    -1,    -1,    -1, 3, CHK_NONE,      0,     0, 0, 0},
        // full diagonal across the coordinate range, tie between zones 0 and 1
        '{ezlr_pkg::ACT_LOAD, -2048, -2048,  2047,  2047, 3, CHK_NONE,      0,     0, 0, 0},
        '{ezlr_pkg::ACT_STEP,     0,     0,     0,     0, 0, CHK_PIXEL, -2048, -2048, 3, 0},
        '{ezlr_pkg::ACT_STEP,     0,     0,     0,     0, 0, CHK_MODEL,     0,     0, 0, 0},
        // replace it mid-line; anti-diagonal, tie between zones 3 and 2
        '{ezlr_pkg::ACT_LOAD,  2047, -2048, -2048,  2047, 2, CHK_NONE,      0,     0, 0, 0},
        '{ezlr_pkg::ACT_STEP,     0,     0,     0,     0, 0, CHK_PIXEL,  2047, -2048, 2, 0},
        '{ezlr_pkg::ACT_STEP,     0,     0,     0,     0, 0, CHK_MODEL,     0,     0, 0, 0},
        // one short line per remaining zone, ties for zones 4 and 7
        '{ezlr_pkg::ACT_LOAD,     0,     0,     3,     5, 0, CHK_NONE,      0,     0, 0, 0},
        '{ezlr_pkg::ACT_STEP,     0,     0,     0,     0, 0, CHK_MODEL,     0,     0, 0, 0},
        '{ezlr_pkg::ACT_LOAD,     0,     0,    -2,     5, 1, CHK_NONE,      0,     0, 0, 0},
        '{ezlr_pkg::ACT_STEP,     0,     0,     0,     0, 0, CHK_MODEL,     0,     0, 0, 0},
        '{ezlr_pkg::ACT_LOAD,     0,     0,    -3,    -3, 2, CHK_NONE,      0,     0, 0, 0},
        '{ezlr_pkg::ACT_STEP,     0,     0,     0,     0, 0, CHK_MODEL,     0,     0, 0, 0},
        '{ezlr_pkg::ACT_LOAD,     0,     0,    -2,    -6, 3, CHK_NONE,      0,     0, 0, 0},
        '{ezlr_pkg::ACT_STEP,     0,     0,     0,     0, 0, CHK_MODEL,     0,     0, 0, 0},
        '{ezlr_pkg::ACT_LOAD,     1,     1,     2,    -5, 0, CHK_NONE,      0,     0, 0, 0},
        '{ezlr_pkg::ACT_STEP,     0,     0,     0,     0, 0, CHK_MODEL,     0,     0, 0, 0},
        '{ezlr_pkg::ACT_LOAD,     0,     0,     4,    -4, 1, CHK_NONE,      0,     0, 0, 0},
        '{ezlr_pkg::ACT_STEP,     0,     0,     0,     0, 0, CHK_MODEL,     0,     0, 0, 0},
        '{ezlr_pkg::ACT_STEP,     0,     0,     0,     0, 0, CHK_MODEL,     0,     0, 0, 0},
        '{ezlr_pkg::ACT_STEP,     0,     0,     0,     0, 0, CHK_MODEL,     0,     0, 0, 0}
    };

    // Clock: 12 ns period
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    eight_zone_line_rasterizer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_x_start     (s_x_start),
        .s_y_start     (s_y_start),
        .s_x_end       (s_x_end),
        .s_y_end       (s_y_end),
        .s_color       (s_color),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_last_pixel  (m_last_pixel)
    );

    // Mirror code of a zone: {swap, negate u, negate v} on the way into zone 0
    function automatic logic [2:0] zone_mirror(ezlr_pkg::zone_t z);
        case (z)
            ezlr_pkg::ZONE_1: return 3'b100;
            ezlr_pkg::ZONE_2: return 3'b101;
            ezlr_pkg::ZONE_3: return 3'b010;
            ezlr_pkg::ZONE_4: return 3'b011;
            ezlr_pkg::ZONE_5: return 3'b111;
            ezlr_pkg::ZONE_6: return 3'b110;
            ezlr_pkg::ZONE_7: return 3'b001;
            default:          return 3'b000;
        endcase
    endfunction

    function automatic ezlr_pkg::zone_t classify_dir(ezlr_pkg::walk_t dx, ezlr_pkg::walk_t dy);
        if (dx >= 0 && dy >= 0)
            return (dx >= dy) ? ezlr_pkg::ZONE_0 : ezlr_pkg::ZONE_1;
        if (dx < 0 && dy >= 0)
            return (-dx >= dy) ? ezlr_pkg::ZONE_3 : ezlr_pkg::ZONE_2;
        if (dx < 0 && dy < 0)
            return (-dx >= -dy) ? ezlr_pkg::ZONE_4 : ezlr_pkg::ZONE_5;
        return (dx >= -dy) ? ezlr_pkg::ZONE_7 : ezlr_pkg::ZONE_6;
    endfunction

    // Swap first, then negate
    function automatic void fold(input logic [2:0] mir,
                                 input ezlr_pkg::walk_t x, input ezlr_pkg::walk_t y,
                                 output ezlr_pkg::walk_t u, output ezlr_pkg::walk_t v);
        ezlr_pkg::walk_t a;
        ezlr_pkg::walk_t b;
        a = mir[MIR_SWAP] ? y : x;
        b = mir[MIR_SWAP] ? x : y;
        u = mir[MIR_NEG_U] ? -a : a;
        v = mir[MIR_NEG_V] ? -b : b;
    endfunction

    // Undo the negation, then the swap
    function automatic void unfold(input logic [2:0] mir,
                                   input ezlr_pkg::walk_t u, input ezlr_pkg::walk_t v,
                                   output ezlr_pkg::walk_t x, output ezlr_pkg::walk_t y);
        ezlr_pkg::walk_t a;
        ezlr_pkg::walk_t b;
        a = mir[MIR_NEG_U] ? -u : u;
        b = mir[MIR_NEG_V] ? -v : v;
        x = mir[MIR_SWAP] ? b : a;
        y = mir[MIR_SWAP] ? a : b;
    endfunction

    // Advance the walker by one beat; returns 1 when the beat yields a pixel
    function automatic logic predict_pixel(input line_cmd_t c, output pixel_t p);
        ezlr_pkg::walk_t dx, dy, u0, v0, u1, v1, du, dv, px, py;
        logic [2:0]      mir;
        p = no_pixel;
        if (c.action == ezlr_pkg::ACT_LOAD) begin
            dx = ezlr_pkg::walk_t'(c.x_end) - ezlr_pkg::walk_t'(c.x_start);
            dy = ezlr_pkg::walk_t'(c.y_end) - ezlr_pkg::walk_t'(c.y_start);
            trace_zone = classify_dir(dx, dy);
            mir = zone_mirror(trace_zone);
            fold(mir, ezlr_pkg::walk_t'(c.x_start), ezlr_pkg::walk_t'(c.y_start), u0, v0);
            fold(mir, ezlr_pkg::walk_t'(c.x_end), ezlr_pkg::walk_t'(c.y_end), u1, v1);
            du = u1 - u0;
            dv = v1 - v0;
            trace_u      = u0;
            trace_v      = v0;
            trace_u_end  = u1;
            trace_dec    = ezlr_pkg::dec_t'(2 * dv - du);
            trace_inc_e  = ezlr_pkg::dec_t'(2 * dv);
            trace_inc_ne = ezlr_pkg::dec_t'(2 * (dv - du));
            trace_color  = c.color;
            trace_active = 1'b1;
            return 1'b0;
        end
        if (!trace_active)
            return 1'b0;
        mir = zone_mirror(trace_zone);
        unfold(mir, trace_u, trace_v, px, py);
        p.x     = coord_t'(px);
        p.y     = coord_t'(py);
        p.color = trace_color;
        p.last  = (trace_u >= trace_u_end);
        if (p.last) begin
            trace_active = 1'b0;
        end else if (trace_dec < 0) begin
            trace_u   = trace_u + 1'b1;
            trace_dec = trace_dec + trace_inc_e;
        end else begin
            trace_u   = trace_u + 1'b1;
            trace_v   = trace_v + 1'b1;
            trace_dec = trace_dec + trace_inc_ne;
        end
        return 1'b1;
    endfunction

    // Idle cycles before a beat, with occasional runs of back-to-back beats
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    function automatic coord_t any_coord();
        return coord_t'($urandom_range(0, 2 ** ezlr_pkg::COORD_BITS - 1));
    endfunction

    function automatic int clamp_coord(int v);
        if (v < COORD_MIN)
            return COORD_MIN;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic line_cmd_t step_beat();
        line_cmd_t c;
        c.action  = ezlr_pkg::ACT_STEP;
        c.x_start = any_coord();
        c.y_start = any_coord();
        c.x_end   = any_coord();
        c.y_end   = any_coord();
        c.color   = 2'($urandom_range(0, 3));
        return c;
    endfunction

    function automatic void match_field(string name, int want, int got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Drive one beat, hold it until accepted, then log what it should produce
    task automatic send_cmd(input line_cmd_t c, input chk_t chk, input pixel_t typed);
        int     gap;
        pixel_t p;
        logic   has_pixel;
        gap = draw_wait(src_calm);
        if (gap > 0) begin
            if (s_valid)
                s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_action  <= c.action;
        s_x_start <= c.x_start;
        s_y_start <= c.y_start;
        s_x_end   <= c.x_end;
        s_y_end   <= c.y_end;
        s_color   <= c.color;
        do @(posedge aclk); while (!s_ready);
        has_pixel = predict_pixel(c, p);
        case (chk)
            CHK_MODEL: if (has_pixel) pending_pixels.push_back(p);
            CHK_PIXEL: pending_pixels.push_back(typed);
            default: ;
        endcase
        beats_sent++;
    endtask

    // Hold the input side until every pending pixel has come out
    task automatic hold_until_drained();
        if (s_valid)
            s_valid <= 1'b0;
        do @(posedge aclk); while (pending_pixels.size() != 0);
    endtask

    // Load a random line and walk it, mostly to the end
    task automatic random_line();
        line_cmd_t c;
        int        kind, reach, dx, dy, len, steps, pick;
        c.action  = ezlr_pkg::ACT_LOAD;
        c.x_start = any_coord();
        c.y_start = any_coord();
        c.color   = 2'($urandom_range(0, 3));
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            c.x_end = any_coord();
            c.y_end = any_coord();
        end else begin
            reach = (kind < 4) ? 100 : 12;
            dx = $urandom_range(0, 2 * reach);
            dy = $urandom_range(0, 2 * reach);
            dx -= reach;
            dy -= reach;
            c.x_end = coord_t'(clamp_coord(int'(c.x_start) + dx));
            c.y_end = coord_t'(clamp_coord(int'(c.y_start) + dy));
        end
        send_cmd(c, CHK_MODEL, no_pixel);

        dx = int'(c.x_end) - int'(c.x_start);
        dy = int'(c.y_end) - int'(c.y_start);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        len = ((dx > dy) ? dx : dy) + 1;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            steps = len + $urandom_range(0, 2);
        else if (pick < 9)
            steps = $urandom_range(1, len);
        else
            steps = $urandom_range(0, 3);
        if (steps > MAX_STEPS_PER_LINE)
            steps = MAX_STEPS_PER_LINE;
        repeat (steps) send_cmd(step_beat(), CHK_MODEL, no_pixel);
    endtask

    // Stimulus: reset, directed table, random lines, drain
    initial begin
        line_cmd_t c;
        pixel_t    typed;
        logic      paused;
        paused = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            c.action    = dir_table[i].act;
            c.x_start   = coord_t'(dir_table[i].xs);
            c.y_start   = coord_t'(dir_table[i].ys);
            c.x_end     = coord_t'(dir_table[i].xe);
            c.y_end     = coord_t'(dir_table[i].ye);
            c.color     = 2'(dir_table[i].col);
            typed.x     = coord_t'(dir_table[i].px);
            typed.y     = coord_t'(dir_table[i].py);
            typed.color = 2'(dir_table[i].pcol);
            typed.last  = dir_table[i].plast[0];
            send_cmd(c, dir_table[i].chk, typed);
        end
        hold_until_drained();

        while (beats_sent < TARGET_BEATS) begin
            if ($urandom_range(0, 11) == 0)
                repeat ($urandom_range(1, 3)) send_cmd(step_beat(), CHK_MODEL, no_pixel);
            random_line();
            if (!paused && beats_sent > TARGET_BEATS / 2) begin
                paused = 1'b1;
                hold_until_drained();
            end
        end

        if (s_valid)
            s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: stall at random before each pixel
    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            stall = draw_wait(snk_calm);
            if (stall > 0) begin
                if (m_ready)
                    m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && aresetn));
        end
    end

    // Compare each accepted pixel with the oldest expectation
    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                error_count++;
                $display("%0t: unexpected pixel, expected none, actual (%0d, %0d)",
                         $time, m_pixel_x, m_pixel_y);
            end else begin
                want = pending_pixels.pop_front();
                match_field("pixel_x", int'(want.x), int'(m_pixel_x));
                match_field("pixel_y", int'(want.y), int'(m_pixel_y));
                match_field("pixel_color", int'(want.color), int'(m_pixel_color));
                match_field("last_pixel", int'(want.last), int'(m_last_pixel));
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_CYCLES);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
